### rtl/core/mbap_pkg.sv
// Shared types and constants for the MBAP deframer.
// No dependencies; imported by mbap_frame_deframer and its test bench.
package mbap_pkg;

  localparam logic [7:0] UnitAny = 8'hFF;
  localparam logic [2:0] HdrLast = 3'd6;
  localparam logic [2:0] InPdu   = 3'd7;

  // Frame verdict codes reported on status
  typedef enum logic [2:0] {
    StInProgress = 3'd0,
    StOk         = 3'd1,
    StProtoBad   = 3'd2,
    StUnitBad    = 3'd3,
    StZeroLen    = 3'd4
  } status_e;

  // Checks in priority order: zero length, protocol, unit.
  function automatic status_e verdict(logic [15:0] len, logic proto_bad, logic unit_bad);
    status_e v;
    if (len == 16'd0) begin
      v = StZeroLen;
    end else if (proto_bad) begin
      v = StProtoBad;
    end else if (unit_bad) begin
      v = StUnitBad;
    end else begin
      v = StOk;
    end
    return v;
  endfunction

endpackage

### rtl/core/mbap_frame_deframer.sv
// Modbus TCP MBAP header deframer, top level.
// Depends on mbap_pkg (constants, status codes, verdict function).
//
// Takes a received TCP byte stream one byte per transaction. The first seven
// bytes of each frame are the MBAP header: transaction ID (ignored), protocol
// ID, big-endian length and unit ID. The next length-1 bytes are the PDU and
// are passed through on pdu_byte_o with pdu_valid_o set; all other results
// carry pdu_byte_o = 0. Every input byte yields exactly one result transaction.
// The frame ends on the last PDU byte, or on the unit byte when the PDU is
// empty (length 0 or 1); that result has frame_done_o set, the PDU length in
// pdu_length_o and a verdict in status_o: zero length first, then nonzero
// protocol ID, then unit mismatch, else ok. A zero length is flagged and the
// next byte starts a new header. PDU bytes are forwarded before the verdict
// is known, so a consumer must drop a bad frame on its own at frame_done_o.
// unit_address (reset 255) is written through the cfg channel, which is always
// ready; 255 matches any unit. Write it only while the block is idle.
// Rate: one byte per clock sustained while out_ready_i stays high. The
// header/PDU counter updates in the cycle a byte is accepted and the result
// appears on the registered output in the cycle after; the single output
// register takes a new byte whenever empty or drained in the same cycle.
module mbap_frame_deframer
  import mbap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pdu_byte_o,
  output logic        pdu_valid_o,
  output logic        frame_done_o,
  output logic [2:0]  status_o,
  output logic [15:0] pdu_length_o
);

  // parse state
  logic [7:0]  unit_addr_q;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [15:0] decl_len_q, decl_len_d;
  logic [15:0] pdu_rem_q, pdu_rem_d;
  logic        proto_bad_q, proto_bad_d;
  logic        unit_bad_q, unit_bad_d;

  // output register
  logic        out_valid_q;
  logic [7:0]  pdu_byte_q, pdu_byte_d;
  logic        pdu_valid_q, pdu_valid_d;
  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic [15:0] plen_q, plen_d;

  logic        in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Next state and result for the accepted byte.
  always_comb begin
    hdr_idx_d   = hdr_idx_q;
    decl_len_d  = decl_len_q;
    pdu_rem_d   = pdu_rem_q;
    proto_bad_d = proto_bad_q;
    unit_bad_d  = unit_bad_q;
    pdu_byte_d  = 8'd0;
    pdu_valid_d = 1'b0;
    done_d      = 1'b0;
    status_d    = StInProgress;
    plen_d      = 16'd0;

    case (hdr_idx_q)
      3'd0, 3'd1: begin
        // transaction ID, ignored
        hdr_idx_d = hdr_idx_q + 3'd1;
      end
      3'd2: begin
        proto_bad_d = (rx_byte_i != 8'd0);
        hdr_idx_d   = 3'd3;
      end
      3'd3: begin
        proto_bad_d = proto_bad_q || (rx_byte_i != 8'd0);
        hdr_idx_d   = 3'd4;
      end
      3'd4: begin
        decl_len_d = {rx_byte_i, 8'd0};
        hdr_idx_d  = 3'd5;
      end
      3'd5: begin
        decl_len_d = {decl_len_q[15:8], rx_byte_i};
        hdr_idx_d  = HdrLast;
      end
      HdrLast: begin
        unit_bad_d = (unit_addr_q != UnitAny) && (rx_byte_i != unit_addr_q);
        if (decl_len_q <= 16'd1) begin
          // empty PDU: frame ends on the unit byte
          done_d    = 1'b1;
          status_d  = verdict(decl_len_q, proto_bad_q, unit_bad_d);
          hdr_idx_d = 3'd0;
        end else begin
          pdu_rem_d = decl_len_q - 16'd1;
          hdr_idx_d = InPdu;
        end
      end
      default: begin
        pdu_byte_d  = rx_byte_i;
        pdu_valid_d = 1'b1;
        pdu_rem_d   = pdu_rem_q - 16'd1;
        if (pdu_rem_q == 16'd1) begin
          done_d    = 1'b1;
          status_d  = verdict(decl_len_q, proto_bad_q, unit_bad_q);
          plen_d    = decl_len_q - 16'd1;
          hdr_idx_d = 3'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_addr_q <= UnitAny;
      hdr_idx_q   <= 3'd0;
      decl_len_q  <= 16'd0;
      pdu_rem_q   <= 16'd0;
      proto_bad_q <= 1'b0;
      unit_bad_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unit_addr_q <= cfg_data_i;
      end
      if (in_acc) begin
        hdr_idx_q   <= hdr_idx_d;
        decl_len_q  <= decl_len_d;
        pdu_rem_q   <= pdu_rem_d;
        proto_bad_q <= proto_bad_d;
        unit_bad_q  <= unit_bad_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pdu_byte_q  <= pdu_byte_d;
      pdu_valid_q <= pdu_valid_d;
      done_q      <= done_d;
      status_q    <= status_d;
      plen_q      <= plen_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pdu_byte_o   = pdu_byte_q;
  assign pdu_valid_o  = pdu_valid_q;
  assign frame_done_o = done_q;
  assign status_o     = status_q;
  assign pdu_length_o = plen_q;

  // Assertions
  // a finished frame always carries a verdict
  a_done_has_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (status_o != StInProgress))
    else $error("frame_done without verdict");

  // no verdict or length outside frame end
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_done_o) |-> (status_o == StInProgress && pdu_length_o == 16'd0))
    else $error("status or length set before frame end");

  // a nonzero length is only reported on the last PDU byte
  a_len_on_pdu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pdu_length_o != 16'd0) |-> (frame_done_o && pdu_valid_o))
    else $error("pdu length outside last pdu byte");

  // every accepted byte produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted byte lost");

  // while the header counter is at the PDU marker, PDU bytes remain pending
  a_rem_in_pdu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_idx_q == InPdu) |-> (pdu_rem_q != 16'd0))
    else $error("in PDU with nothing remaining");

endmodule

### test/mbap_frame_deframer_test.sv
// Self-checking bench for mbap_frame_deframer: directed frame table, then random frames.
// Depends on mbap_pkg (status codes, header constants) and the deframer RTL.
`timescale 1ns / 1ps

module mbap_frame_deframer_test;
  import mbap_pkg::*;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic [7:0]  pdu_byte;
    logic        pdu_valid;
    logic        frame_done;
    status_e     status;
    logic [15:0] pdu_length;
  } frame_res_t;

  // Per-byte note from the sender: an optional typed-in result that replaces
  // the prediction for that byte.
  typedef struct packed {
    logic       pinned;
    frame_res_t res;
  } fixed_res_t;

  // Directed table row: either a unit_address write or one stream byte.
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] val;
    logic       pinned;
    frame_res_t res;
  } dir_row_t;

  localparam frame_res_t ResBusy = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pdu_byte;
  logic        pdu_valid;
  logic        frame_done;
  logic [2:0]  status;
  logic [15:0] pdu_length;

  // Deframer state as the bench tracks it; starts at the reset values.
  logic [7:0]  unit_sel  = UnitAny;
  logic [2:0]  hdr_pos   = 3'd0;
  logic [15:0] len_field = 16'd0;
  logic [15:0] pdu_left  = 16'd0;
  logic        proto_err = 1'b0;
  logic        unit_err  = 1'b0;

  frame_res_t  pending_res_q[$];
  fixed_res_t  fixed_res_q[$];
  int unsigned err_cnt    = 0;
  int unsigned bytes_sent = 0;
  logic        gap_en     = 1'b0;
  logic        stall_en   = 1'b0;
  int unsigned stall_left = 0;

  // Directed frames:
  //  - zero length with any unit (reset setting): ends on the unit byte
  //  - length one with a nonzero protocol ID: empty PDU, protocol verdict
  //  - unit 1 configured, length two with unit 2: the PDU byte goes out
  //    valid and the same transaction carries the unit-mismatch verdict
  dir_row_t dir_tab [23] = '{
    '{1'b0, 8'hFF, 1'b1, ResBusy},
    '{1'b0, 8'hFF, 1'b1, ResBusy},
    '{1'b0, 8'h00, 1'b1, ResBusy},
    '{1'b0, 8'h00, 1'b1, ResBusy},
    '{1'b0, 8'h00, 1'b1, ResBusy},
    '{1'b0, 8'h00, 1'b1, ResBusy},
    '{1'b0, 8'h5A, 1'b1, '{8'h00, 1'b0, 1'b1, StZeroLen, 16'h0000}},
    '{1'b0, 8'h12, 1'b0, ResBusy},
    '{1'b0, 8'h34, 1'b0, ResBusy},
    '{1'b0, 8'h80, 1'b0, ResBusy},
    '{1'b0, 8'h01, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h01, 1'b0, ResBusy},
    '{1'b0, 8'h5A, 1'b1, '{8'h00, 1'b0, 1'b1, StProtoBad, 16'h0000}},
    '{1'b1, 8'h01, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h00, 1'b0, ResBusy},
    '{1'b0, 8'h02, 1'b0, ResBusy},
    '{1'b0, 8'h02, 1'b0, ResBusy},
    '{1'b0, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, StUnitBad, 16'h0001}}
  };

  mbap_frame_deframer u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pdu_byte_o   (pdu_byte),
    .pdu_valid_o  (pdu_valid),
    .frame_done_o (frame_done),
    .status_o     (status),
    .pdu_length_o (pdu_length)
  );

  always #4 clk = ~clk;

  // Verdict priority: zero length, then protocol, then unit.
  function automatic status_e frame_verdict();
    status_e v;
    if (len_field == 16'd0) begin
      v = StZeroLen;
    end else if (proto_err) begin
      v = StProtoBad;
    end else if (unit_err) begin
      v = StUnitBad;
    end else begin
      v = StOk;
    end
    return v;
  endfunction

  // Advances the tracked state by one stream byte and returns the result
  // transaction the deframer owes for it. Header positions 0..6 are the
  // MBAP bytes in wire order; InPdu means PDU bytes are streaming.
  function automatic frame_res_t deframe_step(logic [7:0] b);
    frame_res_t r;
    r = ResBusy;
    case (hdr_pos)
      3'd0, 3'd1: begin
        hdr_pos = hdr_pos + 3'd1;   // transaction ID, ignored
      end
      3'd2: begin
        proto_err = (b != 8'h00);
        hdr_pos   = 3'd3;
      end
      3'd3: begin
        proto_err = proto_err || (b != 8'h00);
        hdr_pos   = 3'd4;
      end
      3'd4: begin
        len_field = {b, 8'h00};
        hdr_pos   = 3'd5;
      end
      3'd5: begin
        len_field[7:0] = b;
        hdr_pos        = HdrLast;
      end
      HdrLast: begin
        unit_err = (unit_sel != UnitAny) && (b != unit_sel);
        if (len_field <= 16'd1) begin
          // empty PDU: frame closes on the unit byte
          r.frame_done = 1'b1;
          r.status     = frame_verdict();
          hdr_pos      = 3'd0;
        end else begin
          pdu_left = len_field - 16'd1;
          hdr_pos  = InPdu;
        end
      end
      default: begin
        r.pdu_byte  = b;
        r.pdu_valid = 1'b1;
        pdu_left    = pdu_left - 16'd1;
        if (pdu_left == 16'd0) begin
          r.frame_done = 1'b1;
          r.status     = frame_verdict();
          r.pdu_length = len_field - 16'd1;
          hdr_pos      = 3'd0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (err_cnt < 40) begin
        $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      end
      err_cnt++;
    end
  endtask

  // Sink side: random bursts of back-pressure while stall_en is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: all three channels are sampled in this one block, in a fixed
  // order, so a config write and a byte on the same edge stay consistent.
  always @(posedge clk) begin
    frame_res_t got;
    frame_res_t want;
    fixed_res_t note;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{pdu_byte, pdu_valid, frame_done, status_e'(status), pdu_length};
        if (pending_res_q.size() == 0) begin
          if (err_cnt < 40) begin
            $display("%0t ns: unexpected result transaction byte %0h valid %0b done %0b",
                     $time, got.pdu_byte, got.pdu_valid, got.frame_done);
          end
          err_cnt++;
        end else begin
          want = pending_res_q.pop_front();
          check_field("pdu_byte", 16'(want.pdu_byte), 16'(got.pdu_byte));
          check_field("pdu_valid", 16'(want.pdu_valid), 16'(got.pdu_valid));
          check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("pdu_length", want.pdu_length, got.pdu_length);
        end
      end
      if (cfg_valid && cfg_ready) begin
        unit_sel = cfg_data;
      end
      if (in_valid && in_ready) begin
        want = deframe_step(rx_byte);
        note = fixed_res_q.pop_front();
        pending_res_q.push_back(note.pinned ? note.res : want);
      end
    end
  end

  // Holds one byte on the input channel until the transaction completes,
  // then maybe drops valid for a random gap. Valid is left high otherwise,
  // so back-to-back bytes never see valid lowered and raised in one step.
  task automatic send_byte(logic [7:0] b, logic pinned, frame_res_t res);
    fixed_res_q.push_back('{pinned, res});
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (gap_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res_q.size() != 0 || fixed_res_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_unit(logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(logic [15:0] len, logic [15:0] proto, logic [7:0] unit);
    send_byte(8'($urandom), 1'b0, ResBusy);
    send_byte(8'($urandom), 1'b0, ResBusy);
    send_byte(proto[15:8], 1'b0, ResBusy);
    send_byte(proto[7:0], 1'b0, ResBusy);
    send_byte(len[15:8], 1'b0, ResBusy);
    send_byte(len[7:0], 1'b0, ResBusy);
    send_byte(unit, 1'b0, ResBusy);
    for (int i = 1; i < int'(len); i++) begin
      send_byte(8'($urandom), 1'b0, ResBusy);
    end
  endtask

  // Mostly well-formed short frames; a share carry a bad protocol ID or a
  // foreign unit, and about one in eight runs 12 to 299 PDU bytes.
  task automatic send_random_frame();
    int unsigned r;
    logic [15:0] len;
    logic [15:0] proto;
    logic [7:0]  unit;
    r = $urandom_range(0, 99);
    if (r < 7) begin
      len = 16'd0;
    end else if (r < 14) begin
      len = 16'd1;
    end else if (r < 88) begin
      len = 16'($urandom_range(2, 12));
    end else begin
      len = 16'($urandom_range(13, 300));
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      proto = 16'($urandom);
    end else if (r == 1) begin
      proto = 16'h0001 << $urandom_range(0, 15);
    end else begin
      proto = 16'h0000;
    end
    r = $urandom_range(0, 9);
    if (r < 5) begin
      unit = unit_sel;
    end else if (r < 7) begin
      unit = UnitAny;
    end else begin
      unit = 8'($urandom);
    end
    send_frame(len, proto, unit);
  endtask

  initial begin
    int unsigned phase_start;
    logic [7:0]  unit_val;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the reset setting of unit_address is in force until
    // the table's own write.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        write_unit(dir_tab[i].val);
      end else begin
        send_byte(dir_tab[i].val, dir_tab[i].pinned, dir_tab[i].res);
      end
    end

    // Random phases, each opened by its own unit_address write. The last phase runs
    // with no idling on either side.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0, 5:    unit_val = 8'h00;
        1:       unit_val = UnitAny;
        3:       unit_val = 8'hFE;
        default: unit_val = 8'($urandom_range(1, 253));
      endcase
      write_unit(unit_val);
      gap_en = (p != 5) && ($urandom_range(0, 3) != 0);
      stall_en <= (p != 5) && ($urandom_range(0, 3) != 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 140) begin
        send_random_frame();
      end
    end

    // Header of the longest legal frame (length field 0xFFFF, unit matching
    // the setting) and its first PDU bytes; the frame is left open.
    send_byte(8'($urandom), 1'b0, ResBusy);
    send_byte(8'($urandom), 1'b0, ResBusy);
    send_byte(8'h00, 1'b0, ResBusy);
    send_byte(8'h00, 1'b0, ResBusy);
    send_byte(8'hFF, 1'b0, ResBusy);
    send_byte(8'hFF, 1'b0, ResBusy);
    send_byte(8'h00, 1'b0, ResBusy);
    for (int i = 0; i < 48; i++) begin
      send_byte(8'($urandom), 1'b0, ResBusy);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest passing run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
